[sv/pvd_pkg.sv]
`timescale 1ns / 1ps
// shared widths, register index codes, stage counts and the power-of-two table
// builder for the particle velocity drag block; no dependencies
package pvd_pkg;

  localparam int unsigned DRAG_W     = 23;
  localparam int unsigned TSTEP_W    = 25;
  localparam int unsigned SIZE_W     = 16;
  localparam int unsigned VEL_W      = 32;
  localparam int unsigned FACT_W     = 17;
  localparam int unsigned X24_W      = 29;
  localparam int unsigned TBL_W      = 31;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 25;

  // pipeline depth of each unit
  localparam int unsigned EXPO_STAGES   = 3;
  localparam int unsigned FACTOR_STAGES = 5;
  localparam int unsigned SCALE_STAGES  = 1;

  // register index codes
  localparam logic [CFG_IDX_W-1:0] CFG_DRAG    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TSTEP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZEREL = 2'd2;

  localparam logic [DRAG_W-1:0]  DRAG_RESET = 23'd65536;
  localparam logic [DRAG_W-1:0]  DRAG_MAX   = 23'd6553600;
  localparam logic [SIZE_W-1:0]  SIZE_UNIT  = 16'd256;
  localparam logic [30:0]        LOG2E_Q30  = 31'd1549082005;

  typedef struct packed {
    logic             over;
    logic [X24_W-1:0] x24;
  } expo_t;

  // floor square root, elaboration time only
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitv;
    rem  = v;
    res  = '0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // 2^(-k/2^bits) in Q.30, built from repeated square roots of one half
  function automatic logic [63:0] pow_entry(input int unsigned bits, input int unsigned k);
    logic [63:0] roots [13];
    logic [63:0] val;
    roots[0] = 64'd1 << 29;
    for (int i = 1; i < 13; i++) begin
      roots[i] = (i <= bits) ? isqrt64(roots[i-1] << 30) : 64'd0;
    end
    val = 64'd1 << 30;
    for (int j = 0; j < 12; j++) begin
      if ((j < bits) && k[j]) begin
        val = (val * roots[bits-j] + (64'd1 << 29)) >> 30;
      end
    end
    if (k == (32'd1 << bits)) begin
      val = 64'd1 << 29;
    end
    return val;
  endfunction

endpackage

[sv/pvd_expo.sv]
`timescale 1ns / 1ps
// exponent unit: drag * time step * size, split into partial products,
// reduced to units of 2^-24 with an over-range flag; uses pvd_pkg
module pvd_expo (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [pvd_pkg::DRAG_W-1:0]  drag_i,
  input  logic [pvd_pkg::TSTEP_W-1:0] tstep_i,
  input  logic                        size_rel_i,
  input  logic [pvd_pkg::SIZE_W-1:0]  size_i,
  output pvd_pkg::expo_t              expo_o
);

  localparam logic [40:0] X24_LIM = 41'd268435456;

  logic [pvd_pkg::DRAG_W-1:0] drag_c;
  logic [47:0]                p_d, p_q;
  logic [pvd_pkg::SIZE_W-1:0] size_d, size_q;
  logic [39:0]                hi_d, hi_q, lo_d, lo_q;
  logic [40:0]                x24_w;
  pvd_pkg::expo_t             expo_d, expo_q;

  always_comb begin
    drag_c = (drag_i > pvd_pkg::DRAG_MAX) ? pvd_pkg::DRAG_MAX : drag_i;
    p_d    = 48'(drag_c) * 48'(tstep_i);
    size_d = size_rel_i ? size_i : pvd_pkg::SIZE_UNIT;
    hi_d   = 40'(p_q[47:24]) * 40'(size_q);
    lo_d   = 40'(p_q[23:0]) * 40'(size_q);
    x24_w  = {1'b0, hi_q} + 41'(lo_q[39:24]);
    // exponent above sixteen means factor zero
    expo_d.over = (x24_w > X24_LIM) || ((x24_w == X24_LIM) && (lo_q[23:0] != '0));
    expo_d.x24  = x24_w[pvd_pkg::X24_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q    <= p_d;
      size_q <= size_d;
      hi_q   <= hi_d;
      lo_q   <= lo_d;
      expo_q <= expo_d;
    end
  end

  assign expo_o = expo_q;

endmodule

[sv/pvd_factor.sv]
`timescale 1ns / 1ps
// damping factor unit: log2(e) scaling, table rom with interpolation and
// the integer power-of-two shift, five stages; uses pvd_pkg
module pvd_factor #(
  parameter int unsigned EXP_TABLE_BITS = 8
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  pvd_pkg::expo_t               expo_i,
  output logic [pvd_pkg::FACT_W-1:0]   factor_o
);

  localparam int unsigned TBL_N = 1 << EXP_TABLE_BITS;
  localparam int unsigned R_W   = 32 - EXP_TABLE_BITS;
  localparam int unsigned M_W   = pvd_pkg::TBL_W + R_W;

  logic [pvd_pkg::TBL_W-1:0] tbl [TBL_N+1];

  for (genvar g = 0; g <= TBL_N; g++) begin : g_tbl
    assign tbl[g] = pvd_pkg::TBL_W'(pvd_pkg::pow_entry(EXP_TABLE_BITS, g));
  end

  logic [59:0]               ly_q, ysum;
  logic                      ov4_q, ov5_q, ov6_q, ov7_q;
  logic [36:0]               y_q;
  logic [EXP_TABLE_BITS:0]   k_lo, k_hi;
  logic [pvd_pkg::TBL_W-1:0] tk_q, tk1_q, tk7_q, diff, g_val;
  logic [R_W-1:0]            r_q;
  logic [4:0]                n6_q, n7_q;
  logic [M_W-1:0]            m_q;
  logic [5:0]                sh_rnd, sh_out;
  logic [63:0]               rnd;
  logic [pvd_pkg::FACT_W-1:0] f_d, f_q;

  always_comb begin
    ysum   = ly_q + 60'd2097152;
    k_lo   = {1'b0, y_q[31 -: EXP_TABLE_BITS]};
    k_hi   = k_lo + (EXP_TABLE_BITS+1)'(1);
    diff   = tk_q - tk1_q;
    g_val  = tk7_q - pvd_pkg::TBL_W'(m_q >> R_W);
    sh_rnd = 6'd13 + 6'(n7_q);
    sh_out = 6'd14 + 6'(n7_q);
    rnd    = {33'd0, g_val} + (64'd1 << sh_rnd);
    f_d    = ov7_q ? '0 : pvd_pkg::FACT_W'(rnd >> sh_out);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // y = x * log2(e)
      ly_q  <= 60'(expo_i.x24) * 60'(pvd_pkg::LOG2E_Q30);
      ov4_q <= expo_i.over;
      y_q   <= ysum[58:22];
      ov5_q <= ov4_q;
      // rom reads for both interpolation points
      tk_q  <= tbl[k_lo];
      tk1_q <= tbl[k_hi];
      r_q   <= y_q[R_W-1:0];
      n6_q  <= y_q[36:32];
      ov6_q <= ov5_q;
      m_q   <= M_W'(diff) * M_W'(r_q);
      tk7_q <= tk_q;
      n7_q  <= n6_q;
      ov7_q <= ov6_q;
      f_q   <= f_d;
    end
  end

  assign factor_o = f_q;

endmodule

[sv/pvd_scale.sv]
`timescale 1ns / 1ps
// one velocity lane: magnitude times factor, rounded to nearest, sign
// restored; uses pvd_pkg
module pvd_scale (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [pvd_pkg::VEL_W-1:0]   mag_i,
  input  logic                        neg_i,
  input  logic [pvd_pkg::FACT_W-1:0]  factor_i,
  output logic [pvd_pkg::VEL_W-1:0]   res_o
);

  logic [48:0] prod_q, sum;
  logic        neg_q;
  logic [31:0] mag_r;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= 49'(mag_i) * 49'(factor_i);
      neg_q  <= neg_i;
    end
  end

  always_comb begin
    sum   = prod_q + 49'd32768;
    mag_r = sum[47:16];
    res_o = neg_q ? (32'd0 - mag_r) : mag_r;
  end

endmodule

[sv/particle_velocity_drag_unit.sv]
`timescale 1ns / 1ps
// particle velocity drag, top level: config registers, lane delay line,
// exponent, factor and scale units, output skid buffer; uses pvd_pkg
//
// usage
//   input channel (in_valid_i / in_stall_o) takes one particle per item:
//   three signed Q16.16 velocity components, a Q8.8 size and a last flag
//   output channel (out_valid_o / out_stall_i) gives one damped velocity per
//   item, in order, with the last flag copied through
//   config port: cfg_we_i writes cfg_wdata_i into register cfg_index_i
//   (0 drag, 1 time step, 2 size-relative); other indexes are ignored;
//   write only while no item is in flight
//   path: an item taken at the input runs through the exponent, factor and
//   scale stages and is offered on the output from the skid buffer
//   throughput: one item per cycle unless stalled, set by the fully pipelined
//   datapath (3 exponent, 5 factor and 1 scale stage, then the skid buffer)
//   stall: the two-entry skid buffer at the output keeps the pipeline moving
//   while one result waits; in_stall_o rises only once both entries are full
//   reset: clears valid bits and the skid buffer, drag 1.0, time step 0,
//   size-relative off
module particle_velocity_drag_unit #(
  parameter int unsigned EXP_TABLE_BITS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pvd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [pvd_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [31:0]              vel_x_i,
  input  logic signed [31:0]              vel_y_i,
  input  logic signed [31:0]              vel_z_i,
  input  logic [15:0]                     particle_size_i,
  input  logic                            in_last_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [31:0]              damped_x_o,
  output logic signed [31:0]              damped_y_o,
  output logic signed [31:0]              damped_z_o,
  output logic                            out_last_o
);

  localparam int unsigned VEL_DLY = pvd_pkg::EXPO_STAGES + pvd_pkg::FACTOR_STAGES;
  localparam int unsigned TOT     = VEL_DLY + pvd_pkg::SCALE_STAGES;

  typedef struct packed {
    logic                      neg;
    logic [pvd_pkg::VEL_W-1:0] mag;
  } lane_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        last;
  } res_t;

  // config registers
  logic [pvd_pkg::DRAG_W-1:0]  drag_q;
  logic [pvd_pkg::TSTEP_W-1:0] tstep_q;
  logic                        sizerel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drag_q    <= pvd_pkg::DRAG_RESET;
      tstep_q   <= '0;
      sizerel_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        pvd_pkg::CFG_DRAG:    drag_q    <= cfg_wdata_i[pvd_pkg::DRAG_W-1:0];
        pvd_pkg::CFG_TSTEP:   tstep_q   <= cfg_wdata_i[pvd_pkg::TSTEP_W-1:0];
        pvd_pkg::CFG_SIZEREL: sizerel_q <= cfg_wdata_i[0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // pipeline enable: every stage moves unless the skid buffer is full
  logic [1:0] cnt_q, cnt_d;
  logic       en;
  logic       push, pop;

  assign en         = (cnt_q != 2'd2);
  assign in_stall_o = !en;

  // valid bits travel alongside the data
  logic [TOT-1:0] valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[TOT-2:0], in_valid_i};
    end
  end

  // sign and magnitude of each component, split at the input
  lane_t [2:0] lanes_d;
  lane_t [2:0] lanes_q [VEL_DLY];
  logic        last_q [TOT];

  always_comb begin
    lanes_d[0].neg = vel_x_i[31];
    lanes_d[1].neg = vel_y_i[31];
    lanes_d[2].neg = vel_z_i[31];
    lanes_d[0].mag = vel_x_i[31] ? (32'd0 - vel_x_i) : vel_x_i;
    lanes_d[1].mag = vel_y_i[31] ? (32'd0 - vel_y_i) : vel_y_i;
    lanes_d[2].mag = vel_z_i[31] ? (32'd0 - vel_z_i) : vel_z_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lanes_q[0] <= lanes_d;
      last_q[0]  <= in_last_i;
      for (int i = 1; i < VEL_DLY; i++) begin
        lanes_q[i] <= lanes_q[i-1];
      end
      for (int i = 1; i < TOT; i++) begin
        last_q[i] <= last_q[i-1];
      end
    end
  end

  // exponent and factor
  pvd_pkg::expo_t              expo;
  logic [pvd_pkg::FACT_W-1:0]  factor;

  pvd_expo u_expo (
    .clk_i      (clk_i),
    .en_i       (en),
    .drag_i     (drag_q),
    .tstep_i    (tstep_q),
    .size_rel_i (sizerel_q),
    .size_i     (particle_size_i),
    .expo_o     (expo)
  );

  pvd_factor #(
    .EXP_TABLE_BITS (EXP_TABLE_BITS)
  ) u_factor (
    .clk_i    (clk_i),
    .en_i     (en),
    .expo_i   (expo),
    .factor_o (factor)
  );

  // one scale lane per component
  logic [31:0] scaled [3];

  for (genvar c = 0; c < 3; c++) begin : g_lane
    pvd_scale u_scale (
      .clk_i    (clk_i),
      .en_i     (en),
      .mag_i    (lanes_q[VEL_DLY-1][c].mag),
      .neg_i    (lanes_q[VEL_DLY-1][c].neg),
      .factor_i (factor),
      .res_o    (scaled[c])
    );
  end

  // two-entry skid buffer at the output
  res_t res_d;
  res_t slot_q [2];
  logic wr_ptr_q, rd_ptr_q;

  always_comb begin
    res_d.x    = scaled[0];
    res_d.y    = scaled[1];
    res_d.z    = scaled[2];
    res_d.last = last_q[TOT-1];
  end

  assign push = en && valid_q[TOT-1];
  assign pop  = out_valid_o && !out_stall_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= res_d;
    end
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign damped_x_o  = slot_q[rd_ptr_q].x;
  assign damped_y_o  = slot_q[rd_ptr_q].y;
  assign damped_z_o  = slot_q[rd_ptr_q].z;
  assign out_last_o  = slot_q[rd_ptr_q].last;

endmodule

[sv/pvd_checker.sv]
`timescale 1ns / 1ps
// port-level checks for the particle velocity drag top level, attached by
// bind; uses pvd_pkg for port widths
module pvd_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pvd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [pvd_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            in_valid_i,
  input  logic                            in_stall_o,
  input  logic signed [31:0]              vel_x_i,
  input  logic signed [31:0]              vel_y_i,
  input  logic signed [31:0]              vel_z_i,
  input  logic [15:0]                     particle_size_i,
  input  logic                            in_last_i,
  input  logic                            out_valid_o,
  input  logic                            out_stall_i,
  input  logic signed [31:0]              damped_x_o,
  input  logic signed [31:0]              damped_y_o,
  input  logic signed [31:0]              damped_z_o,
  input  logic                            out_last_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output item dropped under stall");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(damped_x_o) && $stable(damped_y_o)
      && $stable(damped_z_o) && $stable(out_last_o))
    else $error("output payload changed under stall");

  // input side only backs up when the output is held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

  // a free output frees the input on the next cycle
  a_stall_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_o && out_stall_i) |=> !in_stall_o)
    else $error("input still stalled after output drained");

endmodule

bind particle_velocity_drag_unit pvd_checker u_pvd_checker (.*);
